@@ hdl/ohr_pkg.sv @@
// Shared types and constants for the overwriting history ring.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ohr_pkg;

    localparam int SLOTS = 16;              // ring size, 2..64
    localparam int CAP   = SLOTS - 1;       // entries actually held
    localparam int CNT_W = $clog2(SLOTS);   // holds 0..CAP

    localparam int DATA_W = 96;             // score, msg tag, time stamp

    // request kinds
    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_DEQ  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // age cell load selects
    localparam logic [1:0] AGE_HOLD      = 2'd0;
    localparam logic [1:0] AGE_TAKE_NEXT = 2'd1;
    localparam logic [1:0] AGE_TAKE_IN   = 2'd2;
    localparam logic [1:0] AGE_TAKE_HEAD = 2'd3;

    localparam logic signed [31:0] EMPTY_SCORE = -32'sd1;

    typedef struct packed {
        logic signed [31:0] score;
        logic [31:0]        msg_tag;
        logic [31:0]        time_stamp;
    } entry_t;

    typedef struct packed {
        logic [1:0] sel;
    } age_ctl_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } sort_ctl_t;

endpackage

@@ hdl/ohr_age_cell.sv @@
// One cell of the age-ordered chain (oldest entry in cell 0).
// Depends on ohr_pkg.
`timescale 1ns / 1ps

module ohr_age_cell
    import ohr_pkg::*;
(
    input  logic     aclk,
    input  age_ctl_t ctl,
    input  entry_t   in_entry,
    input  entry_t   next_entry,
    input  entry_t   head_entry,
    output entry_t   cell_entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        case (ctl.sel)
            AGE_TAKE_NEXT: entry_next = next_entry;
            AGE_TAKE_IN:   entry_next = in_entry;
            AGE_TAKE_HEAD: entry_next = head_entry;
            default:       entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign cell_entry = entry_reg;

endmodule

@@ hdl/ohr_sort_cell.sv @@
// One cell of the insertion-sort chain: descending score, ties keep arrival order.
// Depends on ohr_pkg.
`timescale 1ns / 1ps

module ohr_sort_cell
    import ohr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sort_ctl_t ctl,
    input  entry_t    new_entry,
    input  logic      prev_before,
    input  logic      prev_valid,
    input  entry_t    prev_entry,
    input  logic      next_valid,
    input  entry_t    next_entry,
    output entry_t    cell_entry,
    output logic      cell_valid,
    output logic      cell_before
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // new entry goes ahead of this one only on a strictly higher score
    assign cell_before = !valid_reg || (new_entry.score > entry_reg.score);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.push && cell_before) begin
            if (prev_before) begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end else begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end else if (ctl.pop) begin
            entry_next = next_entry;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign cell_entry = entry_reg;
    assign cell_valid = valid_reg;

endmodule

@@ hdl/overwriting_history_ring_sorted_readout.sv @@
// History ring that overwrites its oldest entry when full, with sorted readout.
// Depends on ohr_pkg, ohr_age_cell and ohr_sort_cell.
`timescale 1ns / 1ps

// The ring keeps up to SLOTS-1 entries (score, message tag, time stamp) in a
// chain of age cells, oldest in cell 0. An enqueue request (tuser kind 0)
// produces no result; on a full ring the oldest entry is dropped. A dequeue
// request (kind 1) returns the oldest entry, or a result with empty flag set
// (score -1, tags 0) when the ring is empty. A readout request (kind 2)
// returns every held entry, highest score first and oldest first among equal
// scores, without removing anything: the age chain first rotates once through
// cell 0, inserting each entry into the sort chain, then one result per cycle
// leaves as the sort chain shifts out, unless the output stalls. An empty
// ring answers a readout with one empty-flagged result. Kind 3 is accepted
// and ignored. tlast marks the final result of every dequeue or readout. A
// new request is taken once the block is idle and the output register is
// free or being drained in that cycle.

module overwriting_history_ring_sorted_readout
    import ohr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // score[31:0], msg_tag[63:32], time_stamp[95:64]
    input  logic [1:0]        s_tuser,   // kind[1:0]

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // out_score[31:0], out_msg_tag[63:32],
                                         // out_time_stamp[95:64]
    output logic              m_tuser,   // empty_flag[0]
    output logic              m_tlast    // last_flag
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;   // entries held
    logic [CNT_W-1:0] step_reg, step_next;     // remaining load / emit steps

    entry_t in_entry;
    logic   accept;
    logic   out_free;
    logic   do_enq, do_deq, do_rot;

    // output register
    entry_t m_entry_reg, m_entry_next;
    logic   m_valid_reg, m_valid_next;
    logic   m_empty_reg, m_empty_next;
    logic   m_last_reg,  m_last_next;

    // chains
    entry_t    age_q  [CAP];
    age_ctl_t  age_ctl[CAP];
    entry_t    sort_q [CAP];
    logic      sort_v [CAP];
    logic      sort_b [CAP];
    sort_ctl_t sort_ctl;

    assign in_entry.score      = s_tdata[31:0];
    assign in_entry.msg_tag    = s_tdata[63:32];
    assign in_entry.time_stamp = s_tdata[95:64];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign do_enq = accept && (s_tuser == KIND_ENQ);
    assign do_deq = accept && (s_tuser == KIND_DEQ) && (count_reg != '0);
    assign do_rot = (state_reg == ST_LOAD);

    // per-cell select for the age chain
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            age_ctl[i].sel = AGE_HOLD;
            if (do_enq) begin
                if (count_reg == CNT_W'(CAP)) begin
                    // full: drop the oldest, append at the end
                    age_ctl[i].sel = (i == CAP - 1) ? AGE_TAKE_IN : AGE_TAKE_NEXT;
                end else if (count_reg == CNT_W'(i)) begin
                    age_ctl[i].sel = AGE_TAKE_IN;
                end
            end else if (do_deq) begin
                age_ctl[i].sel = AGE_TAKE_NEXT;
            end else if (do_rot) begin
                if (CNT_W'(i) == count_reg - 1'b1) begin
                    age_ctl[i].sel = AGE_TAKE_HEAD;
                end else if (CNT_W'(i) < count_reg) begin
                    age_ctl[i].sel = AGE_TAKE_NEXT;
                end
            end
        end
    end

    // control sequencing
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        m_entry_next = m_entry_reg;
        m_empty_next = m_empty_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        sort_ctl     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        KIND_ENQ: begin
                            if (count_reg != CNT_W'(CAP)) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_DEQ: begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            if (count_reg == '0) begin
                                m_empty_next           = 1'b1;
                                m_entry_next.score      = EMPTY_SCORE;
                                m_entry_next.msg_tag    = '0;
                                m_entry_next.time_stamp = '0;
                            end else begin
                                m_empty_next = 1'b0;
                                m_entry_next = age_q[0];
                                count_next   = count_reg - 1'b1;
                            end
                        end
                        KIND_READ: begin
                            if (count_reg == '0) begin
                                m_valid_next           = 1'b1;
                                m_last_next            = 1'b1;
                                m_empty_next           = 1'b1;
                                m_entry_next.score      = EMPTY_SCORE;
                                m_entry_next.msg_tag    = '0;
                                m_entry_next.time_stamp = '0;
                            end else begin
                                sort_ctl.clear = 1'b1;
                                step_next      = count_reg;
                                state_next     = ST_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                // age cell 0 goes into the sort chain while the age chain rotates
                sort_ctl.push = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == CNT_W'(1)) begin
                    step_next  = count_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    sort_ctl.pop = 1'b1;
                    m_valid_next = 1'b1;
                    m_empty_next = 1'b0;
                    m_entry_next = sort_q[0];
                    m_last_next  = (step_reg == CNT_W'(1));
                    step_next    = step_reg - 1'b1;
                    if (step_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_entry_reg <= m_entry_next;
        m_empty_reg <= m_empty_next;
        m_last_reg  <= m_last_next;
    end

    // age chain
    for (genvar g = 0; g < CAP; g++) begin : g_age
        entry_t nxt;
        if (g < CAP - 1) begin : g_mid
            assign nxt = age_q[g + 1];
        end else begin : g_end
            assign nxt = age_q[g];
        end
        ohr_age_cell u_cell (
            .aclk       (aclk),
            .ctl        (age_ctl[g]),
            .in_entry   (in_entry),
            .next_entry (nxt),
            .head_entry (age_q[0]),
            .cell_entry (age_q[g])
        );
    end

    // sort chain, best entry in cell 0
    for (genvar g = 0; g < CAP; g++) begin : g_sort
        logic   p_before, p_valid, n_valid;
        entry_t p_entry, n_entry;
        if (g == 0) begin : g_first
            assign p_before = 1'b0;
            assign p_valid  = 1'b0;
            assign p_entry  = age_q[0];
        end else begin : g_rest
            assign p_before = sort_b[g - 1];
            assign p_valid  = sort_v[g - 1];
            assign p_entry  = sort_q[g - 1];
        end
        if (g < CAP - 1) begin : g_mid
            assign n_valid = sort_v[g + 1];
            assign n_entry = sort_q[g + 1];
        end else begin : g_end
            assign n_valid = 1'b0;
            assign n_entry = sort_q[g];
        end
        ohr_sort_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (sort_ctl),
            .new_entry   (age_q[0]),
            .prev_before (p_before),
            .prev_valid  (p_valid),
            .prev_entry  (p_entry),
            .next_valid  (n_valid),
            .next_entry  (n_entry),
            .cell_entry  (sort_q[g]),
            .cell_valid  (sort_v[g]),
            .cell_before (sort_b[g])
        );
    end

    assign m_tvalid       = m_valid_reg;
    assign m_tdata[31:0]  = m_entry_reg.score;
    assign m_tdata[63:32] = m_entry_reg.msg_tag;
    assign m_tdata[95:64] = m_entry_reg.time_stamp;
    assign m_tuser        = m_empty_reg;
    assign m_tlast        = m_last_reg;

endmodule

@@ test/tb_overwriting_history_ring_sorted_readout.sv @@
// Self-checking testbench for the overwriting history ring with sorted readout.
// Depends on ohr_pkg and overwriting_history_ring_sorted_readout, and through it on the cells.
`timescale 1ns / 1ps

typedef struct packed {
    ohr_pkg::entry_t ent;
    logic            empty;
    logic            last;
} ring_result_t;

// Shadow copy of the ring; works out what each accepted request should return.
class ring_scoreboard;
    ohr_pkg::entry_t ring [ohr_pkg::SLOTS];
    int              head;
    int              tail;
    ring_result_t    expected_q [$];
    int              errors;

    function new();
        head   = 0;
        tail   = 0;
        errors = 0;
    endfunction

    function ring_result_t empty_result();
        ring_result_t r;
        r.ent.score      = ohr_pkg::EMPTY_SCORE;
        r.ent.msg_tag    = '0;
        r.ent.time_stamp = '0;
        r.empty          = 1'b1;
        r.last           = 1'b1;
        return r;
    endfunction

    // append one expected result at the back of the queue
    function void add_expected(ring_result_t r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_request(logic [1:0] kind, ohr_pkg::entry_t e);
        ohr_pkg::entry_t held [$];
        ohr_pkg::entry_t cur;
        ring_result_t    r;
        int              p;
        int              j;
        case (kind)
            ohr_pkg::KIND_ENQ: begin
                ring[tail] = e;
                tail = (tail + 1) % ohr_pkg::SLOTS;
                // full ring: oldest entry is dropped
                if (tail == head) head = (head + 1) % ohr_pkg::SLOTS;
            end
            ohr_pkg::KIND_DEQ: begin
                if (head == tail) begin
                    add_expected(empty_result());
                end else begin
                    r.ent   = ring[head];
                    r.empty = 1'b0;
                    r.last  = 1'b1;
                    add_expected(r);
                    head = (head + 1) % ohr_pkg::SLOTS;
                end
            end
            ohr_pkg::KIND_READ: begin
                // walk oldest first; insert behind every score >= this one so ties keep age order
                for (p = head; p != tail; p = (p + 1) % ohr_pkg::SLOTS) begin
                    cur = ring[p];
                    j = held.size();
                    while (j > 0 && $signed(cur.score) > $signed(held[j-1].score)) j--;
                    held.insert(j, cur);
                end
                if (held.size() == 0) begin
                    add_expected(empty_result());
                end else begin
                    foreach (held[i]) begin
                        r.ent   = held[i];
                        r.empty = 1'b0;
                        r.last  = (i == held.size() - 1);
                        add_expected(r);
                    end
                end
            end
            default: ;  // unused kind: no result, no state change
        endcase
    endfunction

    function void check_result(ring_result_t got);
        ring_result_t want;
        if (expected_q.size() == 0) begin
            $error("result with nothing expected: out_score %0d", got.ent.score);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.ent.score !== want.ent.score) begin
            $error("out_score expected %0d got %0d", want.ent.score, got.ent.score);
            errors++;
        end
        if (got.ent.msg_tag !== want.ent.msg_tag) begin
            $error("out_msg_tag expected %h got %h", want.ent.msg_tag, got.ent.msg_tag);
            errors++;
        end
        if (got.ent.time_stamp !== want.ent.time_stamp) begin
            $error("out_time_stamp expected %h got %h", want.ent.time_stamp,
                   got.ent.time_stamp);
            errors++;
        end
        if (got.empty !== want.empty) begin
            $error("empty_flag expected %b got %b", want.empty, got.empty);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last_flag expected %b got %b", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_overwriting_history_ring_sorted_readout;
    import ohr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [1:0]        s_tuser = KIND_UNUSED;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    // when set, neither side inserts gaps or stalls
    bit                no_idle = 1'b0;

    ring_scoreboard    board = new();

    overwriting_history_ring_sorted_readout dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Random entry; scores lean toward a few small values (ties) and the extremes.
    function automatic entry_t random_entry();
        entry_t e;
        case ($urandom_range(0, 5))
            0, 1:    e.score = $signed($urandom_range(0, 4)) - 2;
            2:       e.score = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: e.score = $urandom;
        endcase
        e.msg_tag    = $urandom;
        e.time_stamp = $urandom;
        return e;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [1:0] kind, input entry_t e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {e.time_stamp, e.msg_tag, e.score};
        do @(posedge aclk); while (!s_tready);
        board.note_request(kind, e);
        @(negedge aclk);
    endtask

    task automatic take_results();
        int           stall;
        ring_result_t got;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.ent.score      = m_tdata[31:0];
            got.ent.msg_tag    = m_tdata[63:32];
            got.ent.time_stamp = m_tdata[95:64];
            got.empty          = m_tuser;
            got.last           = m_tlast;
            board.check_result(got);
            @(negedge aclk);
        end
    endtask

    initial begin
        entry_t      e;
        entry_t      ones;
        int          sent;
        int          enq_pct;
        int          pick;
        logic [1:0]  kind;

        ones = '1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        fork
            take_results();
        join_none

        // directed: empty ring, unused kind, extreme scores and tags, ties, drain
        send_request(KIND_DEQ, random_entry());
        send_request(KIND_READ, random_entry());
        send_request(KIND_UNUSED, random_entry());
        send_request(KIND_ENQ, ones ^ {1'b1, 95'b0});           // max score, tags all ones
        send_request(KIND_ENQ, {32'sh80000000, 32'h0, 32'h0});  // min score, tags zero
        send_request(KIND_ENQ, {-32'sd1, 32'h1111_0001, 32'h2222_0001});
        send_request(KIND_ENQ, {32'sd0, 32'h1111_0002, 32'h2222_0002});
        send_request(KIND_ENQ, {-32'sd1, 32'h1111_0003, 32'h2222_0003});
        send_request(KIND_ENQ, {32'sh7fffffff, 32'h1111_0004, 32'h2222_0004});
        send_request(KIND_READ, random_entry());
        send_request(KIND_DEQ, random_entry());
        send_request(KIND_READ, random_entry());
        repeat (5) send_request(KIND_DEQ, random_entry());
        send_request(KIND_DEQ, random_entry());
        send_request(KIND_READ, random_entry());

        // random: segments of 20 requests that lean toward filling (and
        // overwriting), mixing, or draining; some segments run without gaps
        sent = 0;
        while (sent < 160) begin
            case ((sent / 20) % 3)
                0:       enq_pct = 92;
                1:       enq_pct = 55;
                default: enq_pct = 20;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (20) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)            kind = KIND_UNUSED;
                else if (pick < enq_pct) kind = KIND_ENQ;
                else if (pick % 2 == 0)  kind = KIND_DEQ;
                else                     kind = KIND_READ;
                e = random_entry();
                send_request(kind, e);
                if (kind != KIND_UNUSED) sent++;
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
